@@ rtl/page_table_replacement_top_macros.svh @@
// Assertion macros for the page table replacement block.
// Used by modules that include this header; expects i_clk and i_rst_n in scope.
`ifndef PAGE_TABLE_REPLACEMENT_TOP_MACROS_SVH
`define PAGE_TABLE_REPLACEMENT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table assertion failed");

`endif

@@ rtl/ptr_pkg.sv @@
// Shared constants, types and helper functions for the page table replacement block.
// No dependencies; used by every other file of the block except the macro header.
`timescale 1ns / 1ps

package ptr_pkg;

    localparam int CAPACITY  = 8;
    localparam int PAGE_BITS = 16;
    localparam int FRAME_W   = $clog2(CAPACITY);
    localparam int AGE_W     = FRAME_W;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int STEP_W    = $clog2(2 * CAPACITY);
    localparam int POLICY_W  = 2;

    localparam logic [POLICY_W-1:0] POLICY_FIFO  = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_LRU   = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_CLOCK = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(CAPACITY - 1);

    typedef struct packed {
        logic [FRAME_W-1:0] idx;
        logic               load;       // write tag and mark the frame valid
        logic               set_ref;
        logic               clr_ref;
        logic               touch;      // make the frame the newest
        logic               touch_all;  // every other valid frame ages
    } t_tbl_cmd;

    typedef struct packed {
        logic                 valid;
        logic                 ref_bit;
        logic [AGE_W-1:0]     age;
        logic [PAGE_BITS-1:0] tag;
        logic                 match;
    } t_tbl_stat;

    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
    } t_result;

    function automatic logic [FRAME_W-1:0] frame_inc(input logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] nxt;
        nxt = (f == FRAME_LAST) ? '0 : f + 1'b1;
        return nxt;
    endfunction

endpackage

@@ rtl/ptr_req_if.sv @@
// Request channel of the page table: valid/ready handshake with a page number.
// Depends on ptr_pkg for the page width.
`timescale 1ns / 1ps

interface ptr_req_if;
    logic                         valid;
    logic                         ready;
    logic [ptr_pkg::PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

@@ rtl/ptr_resp_if.sv @@
// Response channel of the page table: valid/ready handshake with the lookup result.
// Depends on ptr_pkg for the frame and page widths.
`timescale 1ns / 1ps

interface ptr_resp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [ptr_pkg::FRAME_W-1:0]   frame;
    logic                          evicted_valid;
    logic [ptr_pkg::PAGE_BITS-1:0] evicted_page;

    modport source (output valid, output hit, output frame, output evicted_valid,
                    output evicted_page, input ready);
    modport sink   (input valid, input hit, input frame, input evicted_valid,
                    input evicted_page, output ready);
endinterface

@@ rtl/ptr_frame_table.sv @@
// Frame table: tags, valid bits, reference bits and recency ages of all frames.
// Depends on ptr_pkg; driven one frame at a time by ptr_seq.
`timescale 1ns / 1ps

module ptr_frame_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptr_pkg::t_tbl_cmd             i_cmd,
    input  logic [ptr_pkg::PAGE_BITS-1:0] i_page,
    output ptr_pkg::t_tbl_stat            o_stat
);

    logic [ptr_pkg::PAGE_BITS-1:0] r_tags  [ptr_pkg::CAPACITY];
    logic [ptr_pkg::CAPACITY-1:0]  r_valid;
    logic [ptr_pkg::CAPACITY-1:0]  r_ref;
    logic [ptr_pkg::AGE_W-1:0]     r_age   [ptr_pkg::CAPACITY];

    logic [ptr_pkg::AGE_W-1:0] old_age;

    assign old_age = r_age[i_cmd.idx];

    // Single compare port, addressed by the sequencer's frame index.
    always_comb begin
        o_stat.valid   = r_valid[i_cmd.idx];
        o_stat.ref_bit = r_ref[i_cmd.idx];
        o_stat.age     = old_age;
        o_stat.tag     = r_tags[i_cmd.idx];
        o_stat.match   = r_valid[i_cmd.idx] && (r_tags[i_cmd.idx] == i_page);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tags[i_cmd.idx] <= i_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ref   <= '0;
            for (int i = 0; i < ptr_pkg::CAPACITY; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_valid[i_cmd.idx] <= 1'b1;
            end
            if (i_cmd.set_ref) begin
                r_ref[i_cmd.idx] <= 1'b1;
            end else if (i_cmd.clr_ref) begin
                r_ref[i_cmd.idx] <= 1'b0;
            end
            if (i_cmd.touch) begin
                // Valid frames younger than the touched one (all of them with touch_all) move back one rank.
                for (int i = 0; i < ptr_pkg::CAPACITY; i++) begin
                    if (ptr_pkg::FRAME_W'(i) == i_cmd.idx) begin
                        r_age[i] <= '0;
                    end else if (r_valid[i] && (i_cmd.touch_all || r_age[i] < old_age) &&
                                 r_age[i] < ptr_pkg::AGE_W'(ptr_pkg::CAPACITY - 1)) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/ptr_seq.sv @@
// Sequencer: walks the frame table one frame per cycle for lookup, LRU search
// and clock sweep, then commits the update. Depends on ptr_pkg and the macro header.
`timescale 1ns / 1ps
`include "page_table_replacement_top_macros.svh"

module ptr_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [ptr_pkg::PAGE_BITS-1:0] i_page,
    input  logic [ptr_pkg::POLICY_W-1:0]  i_policy,
    output logic                          o_res_valid,
    input  logic                          i_res_free,
    output ptr_pkg::t_result              o_res,
    output ptr_pkg::t_tbl_cmd             o_cmd,
    output logic [ptr_pkg::PAGE_BITS-1:0] o_page,
    input  ptr_pkg::t_tbl_stat            i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_LRU_SCAN,
        S_CLOCK_SWEEP,
        S_UPDATE,
        S_RESP
    } t_state;

    t_state                        r_state,    n_state;
    logic [ptr_pkg::FRAME_W-1:0]   r_idx,      n_idx;
    logic [ptr_pkg::PAGE_BITS-1:0] r_page,     n_page;
    logic [ptr_pkg::COUNT_W-1:0]   r_count,    n_count;
    logic [ptr_pkg::FRAME_W-1:0]   r_fifo_ptr, n_fifo_ptr;
    logic [ptr_pkg::FRAME_W-1:0]   r_hand,     n_hand;
    logic [ptr_pkg::STEP_W-1:0]    r_step,     n_step;
    logic [ptr_pkg::FRAME_W-1:0]   r_best,     n_best;
    logic [ptr_pkg::AGE_W-1:0]     r_best_age, n_best_age;
    logic                          r_found,    n_found;
    logic                          r_hit,      n_hit;
    logic                          r_evict,    n_evict;
    logic                          r_fill,     n_fill;
    logic [ptr_pkg::PAGE_BITS-1:0] r_ev_page,  n_ev_page;

    logic lru_take;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP) && i_res_free;
    assign o_page      = r_page;

    assign o_res.hit           = r_hit;
    assign o_res.frame         = r_idx;
    assign o_res.evicted_valid = r_evict;
    assign o_res.evicted_page  = r_ev_page;

    assign lru_take = i_stat.valid && (!r_found || (i_stat.age > r_best_age));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_page     = r_page;
        n_count    = r_count;
        n_fifo_ptr = r_fifo_ptr;
        n_hand     = r_hand;
        n_step     = r_step;
        n_best     = r_best;
        n_best_age = r_best_age;
        n_found    = r_found;
        n_hit      = r_hit;
        n_evict    = r_evict;
        n_fill     = r_fill;
        n_ev_page  = r_ev_page;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_page  = i_page;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_evict = 1'b0;
                    n_fill  = 1'b0;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_stat.match) begin
                    n_hit   = 1'b1;
                    n_state = S_UPDATE;
                end else if (r_idx == ptr_pkg::FRAME_LAST) begin
                    if (r_count < ptr_pkg::COUNT_W'(ptr_pkg::CAPACITY)) begin
                        // Free frames are handed out in ascending order.
                        n_fill  = 1'b1;
                        n_idx   = r_count[ptr_pkg::FRAME_W-1:0];
                        n_state = S_UPDATE;
                    end else begin
                        n_evict = 1'b1;
                        unique case (i_policy)
                            ptr_pkg::POLICY_LRU: begin
                                n_idx      = '0;
                                n_found    = 1'b0;
                                n_best     = '0;
                                n_best_age = '0;
                                n_state    = S_LRU_SCAN;
                            end
                            ptr_pkg::POLICY_CLOCK: begin
                                n_idx   = r_hand;
                                n_step  = '0;
                                n_state = S_CLOCK_SWEEP;
                            end
                            default: begin
                                n_idx      = r_fifo_ptr;
                                n_fifo_ptr = ptr_pkg::frame_inc(r_fifo_ptr);
                                n_state    = S_UPDATE;
                            end
                        endcase
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LRU_SCAN: begin
                if (lru_take) begin
                    n_best     = r_idx;
                    n_best_age = i_stat.age;
                    n_found    = 1'b1;
                end
                if (r_idx == ptr_pkg::FRAME_LAST) begin
                    n_idx   = lru_take ? r_idx : r_best;
                    n_state = S_UPDATE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CLOCK_SWEEP: begin
                if (i_stat.valid && !i_stat.ref_bit) begin
                    n_hand  = ptr_pkg::frame_inc(r_idx);
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.clr_ref = i_stat.valid;
                    n_idx         = ptr_pkg::frame_inc(r_idx);
                    if (r_step == ptr_pkg::STEP_W'(2 * ptr_pkg::CAPACITY - 1)) begin
                        // Two full turns without a clear bit: take the frame under the hand.
                        n_hand  = ptr_pkg::frame_inc(ptr_pkg::frame_inc(r_idx));
                        n_state = S_UPDATE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_UPDATE: begin
                o_cmd.load      = !r_hit;
                o_cmd.set_ref   = 1'b1;
                o_cmd.touch     = 1'b1;
                o_cmd.touch_all = r_fill;
                n_ev_page       = r_evict ? i_stat.tag : '0;
                if (r_fill) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_count    <= '0;
            r_fifo_ptr <= '0;
            r_hand     <= '0;
            r_step     <= '0;
            r_best     <= '0;
            r_best_age <= '0;
            r_found    <= 1'b0;
            r_hit      <= 1'b0;
            r_evict    <= 1'b0;
            r_fill     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_page     <= n_page;
            r_count    <= n_count;
            r_fifo_ptr <= n_fifo_ptr;
            r_hand     <= n_hand;
            r_step     <= n_step;
            r_best     <= n_best;
            r_best_age <= n_best_age;
            r_found    <= n_found;
            r_hit      <= n_hit;
            r_evict    <= n_evict;
            r_fill     <= n_fill;
            r_ev_page  <= n_ev_page;
        end
    end

    `PTR_ASSERT_NEXT(a_accept_starts_lookup, i_req_valid && o_req_ready, r_state == S_LOOKUP)
    `PTR_ASSERT_SAME(a_count_bound, 1'b1, r_count <= ptr_pkg::COUNT_W'(ptr_pkg::CAPACITY))
    `PTR_ASSERT_SAME(a_outcome_exclusive, r_state == S_UPDATE, !(r_hit && (r_evict || r_fill)) && !(r_evict && r_fill))
    `PTR_ASSERT_SAME(a_fill_in_order, r_state == S_UPDATE && r_fill, r_idx == r_count[ptr_pkg::FRAME_W-1:0])

endmodule

@@ rtl/page_table_replacement_top.sv @@
// Top level of the page table replacement block: policy register, result register,
// sequencer and frame table. Depends on ptr_pkg, ptr_req_if, ptr_resp_if and submodules.
//
//   Channel  | Dir | Handshake         | Contents
//   i_req    | in  | valid/ready       | page_number
//   o_resp   | out | valid/ready       | hit, frame, evicted_valid, evicted_page
//   i_cfg_*  | in  | write enable only | policy (2 bits)
//
// A request steps through lookup, which scans frames until a hit or the last frame, then
// update and response; an LRU eviction adds a scan of all frames and a clock eviction a
// sweep of up to two turns, set by the frame table's single compare port stepped by the sequencer.
// Reset is synchronous and needs no clearing pass; ready is low while a request is in work.
// A finished result sits in the output register; the next request is accepted meanwhile,
// and its own result waits only if the output register is still occupied.
`timescale 1ns / 1ps

module page_table_replacement_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ptr_req_if.sink                      i_req,
    ptr_resp_if.source                   o_resp,
    input  logic                         i_cfg_we,
    input  logic [ptr_pkg::POLICY_W-1:0] i_cfg_wdata
);

    logic [ptr_pkg::POLICY_W-1:0]  r_policy;
    logic                          r_out_valid;
    ptr_pkg::t_result              r_out;

    logic                          res_valid;
    logic                          res_free;
    ptr_pkg::t_result              res;
    ptr_pkg::t_tbl_cmd             tbl_cmd;
    ptr_pkg::t_tbl_stat            tbl_stat;
    logic [ptr_pkg::PAGE_BITS-1:0] tbl_page;

    assign res_free = !r_out_valid || o_resp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= ptr_pkg::POLICY_FIFO;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_resp.valid         = r_out_valid;
    assign o_resp.hit           = r_out.hit;
    assign o_resp.frame         = r_out.frame;
    assign o_resp.evicted_valid = r_out.evicted_valid;
    assign o_resp.evicted_page  = r_out.evicted_page;

    ptr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_page      (i_req.page_number),
        .i_policy    (r_policy),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_res       (res),
        .o_cmd       (tbl_cmd),
        .o_page      (tbl_page),
        .i_stat      (tbl_stat)
    );

    ptr_frame_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_page  (tbl_page),
        .o_stat  (tbl_stat)
    );

endmodule
